>>> rtl/btom_pkg.sv
// btom_pkg: shared types and constants of the busy time overlap monitor
// no dependencies; imported by btom_div, busy_time_overlap_monitor_unit and tb
package btom_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = 4;
  localparam int CFG_W = 5;
  localparam int TIME_W = 32;
  localparam int BUSY_W = 48;
  localparam int UTIL_W = 24;
  localparam int CNT_W = 8;
  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = CFG_W'(16);

  typedef enum logic [1:0] {
    ACT_INIT   = 2'd0,
    ACT_START  = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_REPORT = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_SLOT    = 3'd1,
    ST_NOT_STARTED = 3'd2,
    ST_NEGATIVE    = 3'd3,
    ST_ZERO_RUN    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_DIV
  } fsm_t;

  typedef struct packed {
    action_t             action;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   now;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic [CNT_W-1:0]    overlap_peak;
    logic [31:0]         peak_repeats;
    logic [BUSY_W-1:0]   busy_sum;
    logic [TIME_W-1:0]   run_elapsed;
    logic [UTIL_W-1:0]   utilization;
  } result_t;

endpackage

>>> rtl/btom_div.sv
// btom_div: restoring divider, one quotient bit per cycle, 24-bit quotient
// depends on btom_pkg; the remainder start value must be below the divisor
module btom_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [btom_pkg::TIME_W-1:0]   rem_init,
  input  logic [btom_pkg::UTIL_W-1:0]   low_bits,
  input  logic [btom_pkg::TIME_W-1:0]   divisor,
  output logic                          fin,
  output logic [btom_pkg::UTIL_W-1:0]   quo
);
  import btom_pkg::*;

  localparam int CW = $clog2(UTIL_W);

  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dvs;
  logic [UTIL_W-1:0] sh;
  logic [CW-1:0]     cnt;
  logic              run;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              ge;

  always_comb begin
    trial = {rem, sh[UTIL_W-1]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      fin <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CW'(UTIL_W - 1);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == '0) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= rem_init;
      dvs <= divisor;
      sh  <= low_bits;
    end else if (run) begin
      rem <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      sh  <= {sh[UTIL_W-2:0], ge};
    end
  end

  assign quo = sh;

  assert property (@(posedge clk) disable iff (rst) go |=> run)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) fin |-> !run)
    else $error("divider finished while still running");
  assert property (@(posedge clk) disable iff (rst) fin |=> !fin)
    else $error("divider finish pulse too long");

endmodule

>>> rtl/busy_time_overlap_monitor_unit.sv
// busy_time_overlap_monitor_unit: top level, per-slot activity and overlap monitor
// depends on btom_pkg and btom_div
//
// channel   signals                 direction  handshake
// command   start, busy, cmd        in         taken when start && !busy
// result    done, res               out        one-cycle strobe, no stall
// config    slots_we, slots_data    in         written when slots_we
//
// init, start, finish: item taken, handled in EXEC, result strobe registered; busy is low during it
// report: ends in EXEC if saturated or in error, else waits in DIV for 24 btom_div steps
// busy is high from the cycle after an item is taken until the result strobe
// rst is synchronous; it clears slot flags, counts, busy total and run start
// the result is shown for one cycle only; the receiver cannot hold it off
module busy_time_overlap_monitor_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  btom_pkg::item_t               cmd,
  output logic                          busy,
  output logic                          done,
  output btom_pkg::result_t             res,
  input  logic                          slots_we,
  input  logic [btom_pkg::CFG_W-1:0]    slots_data
);
  import btom_pkg::*;

  localparam logic [CFG_W-1:0] SLOTS_LIM = CFG_W'(SLOTS);

  fsm_t state, state_next;

  item_t             cmd_q;
  logic [CFG_W-1:0]  slots_in_use;
  logic [TIME_W-1:0] slot_start [SLOTS];
  logic [SLOTS-1:0]  slot_started;
  logic [CNT_W-1:0]  open_count;
  logic [CNT_W-1:0]  peak_level;
  logic [31:0]       peak_hits;
  logic [BUSY_W-1:0] busy_total;
  logic [TIME_W-1:0] run_start;

  logic [CFG_W-1:0]  lim;
  logic              slot_ok;
  logic [TIME_W-1:0] st_time;
  logic [TIME_W-1:0] dur;
  logic [BUSY_W:0]   sum_w;
  logic [CNT_W-1:0]  open_inc;
  logic [TIME_W-1:0] run_el;
  logic              util_sat;
  status_t           status_c;
  logic [CNT_W-1:0]  open_next;
  logic [CNT_W-1:0]  peak_next;
  logic [31:0]       hits_next;
  logic [BUSY_W-1:0] busy_next;
  logic              div_go;
  logic              div_fin;
  logic [UTIL_W-1:0] div_quo;

  assign busy = (state != FSM_IDLE);

  always_comb begin
    lim      = (slots_in_use < SLOTS_LIM) ? slots_in_use : SLOTS_LIM;
    slot_ok  = {1'b0, cmd_q.slot} < lim;
    st_time  = slot_start[cmd_q.slot];
    dur      = cmd_q.now - st_time;
    sum_w    = {1'b0, busy_total} + {{(BUSY_W+1-TIME_W){1'b0}}, dur};
    open_inc = (open_count == '1) ? open_count : open_count + CNT_W'(1);
    run_el   = cmd_q.now - run_start;
    util_sat = busy_total[BUSY_W-1:8] >= {{(BUSY_W-8-TIME_W){1'b0}}, run_el};

    status_c  = ST_OK;
    open_next = open_count;
    peak_next = peak_level;
    hits_next = peak_hits;
    busy_next = busy_total;
    unique case (cmd_q.action)
      ACT_INIT: begin
        open_next = '0;
        peak_next = '0;
        hits_next = '0;
        busy_next = '0;
      end
      ACT_START: begin
        if (!slot_ok) begin
          status_c = ST_BAD_SLOT;
        end else begin
          open_next = open_inc;
          if (open_inc > peak_level) begin
            peak_next = open_inc;
            hits_next = '0;
          end else if (open_inc == peak_level && peak_hits != '1) begin
            hits_next = peak_hits + 32'd1;
          end
        end
      end
      ACT_FINISH: begin
        if (!slot_ok) begin
          status_c = ST_BAD_SLOT;
        end else if (!slot_started[cmd_q.slot]) begin
          status_c = ST_NOT_STARTED;
        end else if (cmd_q.now < st_time) begin
          status_c = ST_NEGATIVE;
        end else begin
          busy_next = sum_w[BUSY_W] ? '1 : sum_w[BUSY_W-1:0];
          open_next = (open_count == '0) ? open_count : open_count - CNT_W'(1);
        end
      end
      ACT_REPORT: begin
        if (cmd_q.now < run_start) begin
          status_c = ST_NEGATIVE;
        end else if (cmd_q.now == run_start) begin
          status_c = ST_ZERO_RUN;
        end
      end
      default: status_c = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_go     = 1'b0;
    unique case (state)
      FSM_IDLE: begin
        if (start) state_next = FSM_EXEC;
      end
      FSM_EXEC: begin
        if (cmd_q.action == ACT_REPORT && status_c == ST_OK && !util_sat) begin
          div_go     = 1'b1;
          state_next = FSM_DIV;
        end else begin
          state_next = FSM_IDLE;
        end
      end
      FSM_DIV: begin
        if (div_fin) state_next = FSM_IDLE;
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  btom_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .rem_init (busy_total[TIME_W+7:8]),
    .low_bits ({busy_total[7:0], 16'd0}),
    .divisor  (run_el),
    .fin      (div_fin),
    .quo      (div_quo)
  );

  // command capture and slot start times
  always_ff @(posedge clk) begin
    if (state == FSM_IDLE && start) cmd_q <= cmd;
    if (state == FSM_EXEC && cmd_q.action == ACT_START && slot_ok) begin
      slot_start[cmd_q.slot] <= cmd_q.now;
    end
  end

  // activity state
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_IN_USE_RST;
      slot_started <= '0;
      open_count   <= '0;
      peak_level   <= '0;
      peak_hits    <= '0;
      busy_total   <= '0;
      run_start    <= '0;
    end else begin
      if (slots_we) slots_in_use <= slots_data;
      if (state == FSM_EXEC) begin
        open_count <= open_next;
        peak_level <= peak_next;
        peak_hits  <= hits_next;
        busy_total <= busy_next;
        if (cmd_q.action == ACT_INIT) begin
          slot_started <= '0;
          run_start    <= cmd_q.now;
        end
        if (cmd_q.action == ACT_START && slot_ok) slot_started[cmd_q.slot] <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == FSM_EXEC && !div_go) || (state == FSM_DIV && div_fin);
    end
  end

  always_ff @(posedge clk) begin
    if (state == FSM_EXEC) begin
      res.status       <= status_c;
      res.overlap_peak <= peak_next;
      res.peak_repeats <= hits_next;
      res.busy_sum     <= busy_next;
      if (cmd_q.action == ACT_REPORT && status_c == ST_OK) begin
        res.run_elapsed <= run_el;
        res.utilization <= util_sat ? '1 : '0;
      end else begin
        res.run_elapsed <= '0;
        res.utilization <= '0;
      end
    end else if (state == FSM_DIV && div_fin) begin
      res.utilization <= div_quo;
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !$past(state == FSM_IDLE))
    else $error("result strobe without an item in work");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  assert property (@(posedge clk) disable iff (rst)
    (done && res.status != ST_OK) |-> (res.utilization == '0 && res.run_elapsed == '0))
    else $error("report fields set on an error result");
  assert property (@(posedge clk) disable iff (rst) peak_level >= open_count)
    else $error("open count above recorded peak");

endmodule

>>> dv/tb.sv
// tb: self-checking testbench for busy_time_overlap_monitor_unit
// drives command items and slot-limit writes, predicts each result and compares it
// depends on rtl/btom_pkg.sv and rtl/busy_time_overlap_monitor_unit.sv
`timescale 1ns / 1ps

module tb;
  import btom_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam logic [BUSY_W-1:0] BUSY_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  item_t cmd = '0;
  logic busy;
  logic done;
  result_t res;
  logic slots_we = 1'b0;
  logic [CFG_W-1:0] slots_data = '0;

  // monitor state as predicted
  logic [TIME_W-1:0] slot_t0 [SLOTS];
  logic [SLOTS-1:0] slot_on = '0;
  logic [CNT_W-1:0] open_cnt = '0;
  logic [CNT_W-1:0] peak_lvl = '0;
  logic [31:0] peak_hits = '0;
  logic [BUSY_W-1:0] busy_tot = '0;
  logic [TIME_W-1:0] run_t0 = '0;
  logic [CFG_W-1:0] cfg_slots = SLOTS_IN_USE_RST;

  result_t pending_results[$];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_cycles = 0;

  always #5 clk = ~clk;

  busy_time_overlap_monitor_unit u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .done(done),
    .res(res),
    .slots_we(slots_we),
    .slots_data(slots_data)
  );

  function automatic result_t predict_monitor(item_t it);
    result_t r;
    logic [63:0] lim;
    logic [63:0] elapsed;
    logic [BUSY_W-1:0] span;
    r = '0;
    r.status = ST_OK;
    lim = (cfg_slots < SLOTS) ? 64'(cfg_slots) : 64'(SLOTS);
    case (it.action)
      ACT_INIT: begin
        slot_on = '0;
        open_cnt = '0;
        peak_lvl = '0;
        peak_hits = '0;
        busy_tot = '0;
        run_t0 = it.now;
      end
      ACT_START: begin
        if (64'(it.slot) >= lim) begin
          r.status = ST_BAD_SLOT;
        end else begin
          slot_t0[it.slot] = it.now;
          slot_on[it.slot] = 1'b1;
          if (open_cnt != '1) open_cnt = open_cnt + 1'b1;
          if (open_cnt > peak_lvl) begin
            peak_lvl = open_cnt;
            peak_hits = '0;
          end else if (open_cnt == peak_lvl && peak_hits != '1) begin
            peak_hits = peak_hits + 1'b1;
          end
        end
      end
      ACT_FINISH: begin
        if (64'(it.slot) >= lim) begin
          r.status = ST_BAD_SLOT;
        end else if (!slot_on[it.slot]) begin
          r.status = ST_NOT_STARTED;
        end else if (it.now < slot_t0[it.slot]) begin
          r.status = ST_NEGATIVE;
        end else begin
          span = BUSY_W'(it.now - slot_t0[it.slot]);
          busy_tot = (busy_tot > BUSY_MAX - span) ? BUSY_MAX : busy_tot + span;
          if (open_cnt != '0) open_cnt = open_cnt - 1'b1;
        end
      end
      default: begin
        if (it.now < run_t0) begin
          r.status = ST_NEGATIVE;
        end else if (it.now == run_t0) begin
          r.status = ST_ZERO_RUN;
        end else begin
          elapsed = 64'(it.now - run_t0);
          r.run_elapsed = it.now - run_t0;
          if (64'(busy_tot) >= (elapsed << 8)) r.utilization = '1;
          else r.utilization = UTIL_W'((64'(busy_tot) << 16) / elapsed);
        end
      end
    endcase
    r.overlap_peak = peak_lvl;
    r.peak_repeats = peak_hits;
    r.busy_sum = busy_tot;
    return r;
  endfunction

  function automatic item_t make_item(action_t a, logic [SLOT_W-1:0] s,
                                      logic [TIME_W-1:0] t);
    item_t it;
    it.action = a;
    it.slot = s;
    it.now = t;
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // callers are just past a falling edge; returns just past a falling edge
  task automatic send_item(item_t it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
      repeat ($urandom_range(1, 30)) @(negedge clk);
    start = 1'b1;
    cmd = it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_monitor(it));
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_slot_limit(logic [CFG_W-1:0] v);
    slots_we = 1'b1;
    slots_data = v;
    @(negedge clk);
    slots_we = 1'b0;
    cfg_slots = v;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item", 64'(res.status), 64'(0));
      end else begin
        want = pending_results.pop_front();
        if (res.status !== want.status)
          report_mismatch("status", 64'(res.status), 64'(want.status));
        if (res.overlap_peak !== want.overlap_peak)
          report_mismatch("overlap_peak", 64'(res.overlap_peak), 64'(want.overlap_peak));
        if (res.peak_repeats !== want.peak_repeats)
          report_mismatch("peak_repeats", 64'(res.peak_repeats), 64'(want.peak_repeats));
        if (res.busy_sum !== want.busy_sum)
          report_mismatch("busy_sum", 64'(res.busy_sum), 64'(want.busy_sum));
        if (res.run_elapsed !== want.run_elapsed)
          report_mismatch("run_elapsed", 64'(res.run_elapsed), 64'(want.run_elapsed));
        if (res.utilization !== want.utilization)
          report_mismatch("utilization", 64'(res.utilization), 64'(want.utilization));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no item or result for %0d cycles", stall_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_directed_cases();
    idle_pct = 7;
    // no init yet: run start is zero
    send_item(make_item(ACT_REPORT, 4'd0, 32'd0));
    send_item(make_item(ACT_REPORT, 4'd9, 32'hFFFF_FFFF));
    send_item(make_item(ACT_FINISH, 4'd3, 32'd10));
    send_item(make_item(ACT_INIT, 4'd5, 32'd1000));
    send_item(make_item(ACT_REPORT, 4'd0, 32'd999));
    send_item(make_item(ACT_REPORT, 4'd0, 32'd1000));
    send_item(make_item(ACT_START, 4'd0, 32'd1000));
    send_item(make_item(ACT_START, 4'd15, 32'hFFFF_FFF0));
    send_item(make_item(ACT_START, 4'd7, 32'd2000));
    send_item(make_item(ACT_FINISH, 4'd15, 32'hFFFF_FFEF));
    send_item(make_item(ACT_FINISH, 4'd15, 32'hFFFF_FFFF));
    send_item(make_item(ACT_FINISH, 4'd0, 32'd1500));
    // restart and finish a slot twice
    send_item(make_item(ACT_START, 4'd0, 32'd1600));
    send_item(make_item(ACT_START, 4'd15, 32'd1700));
    send_item(make_item(ACT_FINISH, 4'd0, 32'd1600));
    send_item(make_item(ACT_FINISH, 4'd0, 32'd1800));
    send_item(make_item(ACT_START, 4'd7, 32'd1900));
    send_item(make_item(ACT_REPORT, 4'd0, 32'd1100));
    send_item(make_item(ACT_REPORT, 4'd0, 32'd1001));
    send_item(make_item(ACT_FINISH, 4'd7, 32'd1899));
    send_item(make_item(ACT_INIT, 4'd0, 32'hFFFF_FFFF));
    send_item(make_item(ACT_REPORT, 4'd15, 32'd0));
    send_item(make_item(ACT_FINISH, 4'd7, 32'hFFFF_FFFF));
    send_item(make_item(ACT_REPORT, 4'd0, 32'hFFFF_FFFF));
  endtask

  task automatic test_slot_limit();
    logic [CFG_W-1:0] limits [5];
    logic [TIME_W-1:0] t;
    limits = '{5'd0, 5'd1, 5'd31, CFG_W'($urandom_range(2, 15)), 5'd16};
    t = 32'd50;
    foreach (limits[i]) begin
      drain_results();
      write_slot_limit(limits[i]);
      send_item(make_item(ACT_INIT, 4'd0, t));
      send_item(make_item(ACT_START, 4'd0, t + 1));
      send_item(make_item(ACT_START, 4'd15, t + 2));
      send_item(make_item(ACT_START, SLOT_W'(limits[i]), t + 3));
      send_item(make_item(ACT_FINISH, 4'd15, t + 10));
      send_item(make_item(ACT_FINISH, 4'd0, t + 11));
      send_item(make_item(ACT_FINISH, SLOT_W'(limits[i]), t + 12));
      send_item(make_item(ACT_REPORT, 4'd0, t + 20));
      t = t + 100;
    end
  endtask

  task automatic test_open_count_saturation();
    idle_pct = 0;
    drain_results();
    write_slot_limit(5'd16);
    send_item(make_item(ACT_INIT, 4'd0, 32'd0));
    for (int i = 0; i < 260; i++)
      send_item(make_item(ACT_START, SLOT_W'(i % 3), 32'(i)));
    for (int i = 0; i < 262; i++)
      send_item(make_item(ACT_FINISH, SLOT_W'(i % 3), 32'(300 + i)));
    send_item(make_item(ACT_START, 4'd2, 32'd700));
    send_item(make_item(ACT_REPORT, 4'd0, 32'd800));
  endtask

  task automatic test_large_spans();
    idle_pct = 0;
    drain_results();
    write_slot_limit(5'd16);
    send_item(make_item(ACT_INIT, 4'd0, 32'd0));
    send_item(make_item(ACT_START, 4'd0, 32'd0));
    repeat (4) send_item(make_item(ACT_FINISH, 4'd0, 32'hFFFF_FFFF));
    send_item(make_item(ACT_REPORT, 4'd0, 32'hFFFF_FFFF));
    send_item(make_item(ACT_REPORT, 4'd0, 32'd1));
  endtask

  task automatic test_random_traffic(int n_items, int pct, logic [CFG_W-1:0] cfg);
    item_t it;
    int pick;
    int lim;
    logic [TIME_W-1:0] t;
    drain_results();
    write_slot_limit(cfg);
    idle_pct = pct;
    lim = (cfg < SLOTS) ? int'(cfg) : SLOTS;
    t = $urandom_range(0, 100000);
    send_item(make_item(ACT_INIT, SLOT_W'($urandom), t));
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 49) == 0) drain_results();
      pick = $urandom_range(0, 99);
      t = t + $urandom_range(0, 40);
      it.now = t;
      it.slot = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(0, 15))
                                            : SLOT_W'($urandom_range(0, lim - 1));
      if (pick < 3) begin
        it.action = ACT_INIT;
      end else if (pick < 48) begin
        it.action = ACT_START;
      end else if (pick < 88) begin
        it.action = ACT_FINISH;
        if ($urandom_range(0, 19) == 0) it.now = t - $urandom_range(0, 200);
      end else if (pick < 95) begin
        it.action = ACT_REPORT;
      end else begin
        it.action = action_t'($urandom_range(0, 3));
        it.slot = SLOT_W'($urandom);
        it.now = $urandom;
      end
      send_item(it);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_cases();
    test_slot_limit();
    test_random_traffic(70, 7, 5'd16);
    test_random_traffic(70, 58, CFG_W'($urandom_range(1, 15)));
    test_random_traffic(70, 0, 5'd31);
    test_open_count_saturation();
    test_large_spans();
    drain_results();
    repeat (30) @(posedge clk);
    while (pending_results.size() != 0)
      report_mismatch("missing result", 64'(pending_results.pop_front().status), 64'(0));
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
